// ----- rtl/core/filmic_tonemap_rgb_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the filmic tonemap block.
// ---------------------------------------------------------------------------
`ifndef FILMIC_TONEMAP_RGB_ASSERT_SVH
`define FILMIC_TONEMAP_RGB_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("filmic tonemap assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define FTM_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("filmic tonemap assertion failed");

`endif

// ----- rtl/core/ftm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ftm_pkg
// Register indexes and curve coefficients of the filmic tonemap block.
// ---------------------------------------------------------------------------
package ftm_pkg;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t REG_WHITE_RED   = 2'd0;
  localparam cfg_idx_t REG_WHITE_GREEN = 2'd1;
  localparam cfg_idx_t REG_WHITE_BLUE  = 2'd2;

  // Curve with exact decimal constants: P(X) = X(319X + 30S),
  // Q(X) = X(22X + 30S) + 6S^2.
  localparam int K_NUM_SQ = 319;
  localparam int K_LIN    = 30;
  localparam int K_DEN_SQ = 22;
  localparam int K_DEN_C  = 6;

endpackage

// ----- rtl/core/ftm_lane.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ftm_lane
// One color channel: curve polynomials, cross products and a pipelined
// restoring divider giving floor(2^OUT_BITS * P(x)Q(w) / (P(w)Q(x))), all ones when x >= w.
// ---------------------------------------------------------------------------
module ftm_lane #(
  parameter int IN_INT_BITS  = 8,
  parameter int IN_FRAC_BITS = 16,
  parameter int OUT_BITS     = 16
) (
  input  logic                                clk,
  input  logic [IN_INT_BITS+IN_FRAC_BITS-1:0] x,
  input  logic [IN_INT_BITS+IN_FRAC_BITS-1:0] w,
  output logic [OUT_BITS-1:0]                 y
);

  localparam int IB = IN_INT_BITS + IN_FRAC_BITS;
  localparam int AW = IB + 9;
  localparam int PW = 2 * IB + 9;
  localparam int H  = (PW + 1) / 2;
  localparam int DW = 2 * PW + 1;

  localparam logic [AW-1:0] LIN_S  = AW'(ftm_pkg::K_LIN) << IN_FRAC_BITS;
  localparam logic [PW-1:0] SIX_SS = PW'(ftm_pkg::K_DEN_C) << (2 * IN_FRAC_BITS);

  // Stage 1: linear factors.
  logic [IB-1:0] x1, w1;
  logic [AW-1:0] ax, bx, aw, bw;
  logic          sat1;

  always_ff @(posedge clk) begin
    x1   <= x;
    w1   <= w;
    ax   <= AW'(x) * AW'(ftm_pkg::K_NUM_SQ) + LIN_S;
    bx   <= AW'(x) * AW'(ftm_pkg::K_DEN_SQ) + LIN_S;
    aw   <= AW'(w) * AW'(ftm_pkg::K_NUM_SQ) + LIN_S;
    bw   <= AW'(w) * AW'(ftm_pkg::K_DEN_SQ) + LIN_S;
    sat1 <= (x >= w);
  end

  // Stage 2: numerator and denominator polynomials.
  logic [PW-1:0] px, qx, pw, qw;
  logic          sat2;

  always_ff @(posedge clk) begin
    px   <= PW'(x1) * PW'(ax);
    qx   <= PW'(x1) * PW'(bx) + SIX_SS;
    pw   <= PW'(w1) * PW'(aw);
    qw   <= PW'(w1) * PW'(bw) + SIX_SS;
    sat2 <= sat1;
  end

  // Stage 3: half-word partial products of the two cross products.
  logic [2*H-1:0] n_ll, n_lh, n_hl, n_hh, d_ll, d_lh, d_hl, d_hh;
  logic           sat3;

  always_ff @(posedge clk) begin
    n_ll <= (2*H)'(px[H-1:0]) * (2*H)'(qw[H-1:0]);
    n_lh <= (2*H)'(px[H-1:0]) * (2*H)'(qw[PW-1:H]);
    n_hl <= (2*H)'(px[PW-1:H]) * (2*H)'(qw[H-1:0]);
    n_hh <= (2*H)'(px[PW-1:H]) * (2*H)'(qw[PW-1:H]);
    d_ll <= (2*H)'(pw[H-1:0]) * (2*H)'(qx[H-1:0]);
    d_lh <= (2*H)'(pw[H-1:0]) * (2*H)'(qx[PW-1:H]);
    d_hl <= (2*H)'(pw[PW-1:H]) * (2*H)'(qx[H-1:0]);
    d_hh <= (2*H)'(pw[PW-1:H]) * (2*H)'(qx[PW-1:H]);
    sat3 <= sat2;
  end

  // Divider pipeline, stage 0 loaded with the summed cross products.
  logic [DW-1:0]       rem [0:OUT_BITS];
  logic [DW-1:0]       dvs [0:OUT_BITS];
  logic [OUT_BITS-1:0] quo [0:OUT_BITS];
  logic                sat [0:OUT_BITS];

  always_ff @(posedge clk) begin
    rem[0] <= (DW'(n_hh) << (2 * H)) + ((DW'(n_lh) + DW'(n_hl)) << H) + DW'(n_ll);
    dvs[0] <= (DW'(d_hh) << (2 * H)) + ((DW'(d_lh) + DW'(d_hl)) << H) + DW'(d_ll);
    quo[0] <= '0;
    sat[0] <= sat3;
  end

  for (genvar k = 0; k < OUT_BITS; k++) begin : g_div
    logic [DW-1:0] shifted;
    logic          fits;

    assign shifted = {rem[k][DW-2:0], 1'b0};
    assign fits    = (shifted >= dvs[k]);

    always_ff @(posedge clk) begin
      rem[k+1] <= fits ? (shifted - dvs[k]) : shifted;
      dvs[k+1] <= dvs[k];
      quo[k+1] <= {quo[k][OUT_BITS-2:0], fits};
      sat[k+1] <= sat[k];
    end
  end

  // The ratio is below one when not saturated, so the quotient fits.
  assign y = sat[OUT_BITS] ? {OUT_BITS{1'b1}} : quo[OUT_BITS];

endmodule

// ----- rtl/core/filmic_tonemap_rgb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// filmic_tonemap_rgb
// Filmic (Hable) tonemapping of one linear RGB pixel, normalized per channel
// by a configurable white point.
// ---------------------------------------------------------------------------
// From start to done, a pixel passes the lane stages, the divider and the merge register.
// Throughput: one pixel every clock; busy never rises, and the receiver has
// no way to stall, so each result is shown for exactly one cycle.
// The depth is set by the divider, which resolves one quotient bit per stage.
// Reset clears the valid pipeline and loads each white point with 11.2.
// ---------------------------------------------------------------------------
module filmic_tonemap_rgb #(
  parameter int IN_INT_BITS  = 8,
  parameter int IN_FRAC_BITS = 16,
  parameter int OUT_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [IN_INT_BITS+IN_FRAC_BITS-1:0] red_in,
  input  logic [IN_INT_BITS+IN_FRAC_BITS-1:0] green_in,
  input  logic [IN_INT_BITS+IN_FRAC_BITS-1:0] blue_in,
  output logic                                done,
  output logic [OUT_BITS-1:0]                 red_out,
  output logic [OUT_BITS-1:0]                 green_out,
  output logic [OUT_BITS-1:0]                 blue_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  ftm_pkg::cfg_idx_t                   cfg_index,
  input  logic [IN_INT_BITS+IN_FRAC_BITS-1:0] cfg_data
);

  localparam int IB  = IN_INT_BITS + IN_FRAC_BITS;
  localparam int LAT = OUT_BITS + 5;
  // Default white point 11.2 in the input format.
  localparam longint WHITE_DEF_L = (longint'(112) << IN_FRAC_BITS) / 10;
  localparam logic [IB-1:0] WHITE_DEF = IB'(WHITE_DEF_L);

  // Every pixel enters the pipeline on the cycle it arrives.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // White point registers. Writes to an index past the blue register are
  // dropped.
  logic [IB-1:0] white_red, white_green, white_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_red   <= WHITE_DEF;
      white_green <= WHITE_DEF;
      white_blue  <= WHITE_DEF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ftm_pkg::REG_WHITE_RED:   white_red   <= cfg_data;
        ftm_pkg::REG_WHITE_GREEN: white_green <= cfg_data;
        ftm_pkg::REG_WHITE_BLUE:  white_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Three identical lanes, one per color channel.
  logic [OUT_BITS-1:0] red_y, green_y, blue_y;

  ftm_lane #(.IN_INT_BITS(IN_INT_BITS), .IN_FRAC_BITS(IN_FRAC_BITS),
             .OUT_BITS(OUT_BITS)) u_red (
    .clk(clk), .x(red_in), .w(white_red), .y(red_y));

  ftm_lane #(.IN_INT_BITS(IN_INT_BITS), .IN_FRAC_BITS(IN_FRAC_BITS),
             .OUT_BITS(OUT_BITS)) u_green (
    .clk(clk), .x(green_in), .w(white_green), .y(green_y));

  ftm_lane #(.IN_INT_BITS(IN_INT_BITS), .IN_FRAC_BITS(IN_FRAC_BITS),
             .OUT_BITS(OUT_BITS)) u_blue (
    .clk(clk), .x(blue_in), .w(white_blue), .y(blue_y));

  // A valid bit travels beside each pixel. The lanes carry no control, so
  // this shift line alone decides when a word is presented.
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  // Merge stage: the three channel results are registered together and
  // leave as one word.
  always_ff @(posedge clk) begin
    red_out   <= red_y;
    green_out <= green_y;
    blue_out  <= blue_y;
  end

  assign done = vld[LAT-1];

endmodule

// ----- rtl/core/ftm_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ftm_checker
// Port-level checks of the filmic tonemap block, bound to the top level.
// ---------------------------------------------------------------------------
`include "filmic_tonemap_rgb_assert.svh"

module ftm_checker #(
  parameter int LAT = 21
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_ready
);

  `FTM_ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `FTM_ASSERT_IMP(a_cfg_open, 1'b1, cfg_ready)
  `FTM_ASSERT_DLY(a_word_out, start && !busy, LAT, done)
  `FTM_ASSERT_IMP(a_no_stray_word, done, $past(start, LAT))

endmodule

bind filmic_tonemap_rgb ftm_checker #(.LAT(LAT)) u_ftm_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for filmic_tonemap_rgb. Pixels go in as bursts from a
// pending queue, the white points move between phases, and every result word
// is compared with an exact integer prediction of the normalized curve.
// ---------------------------------------------------------------------------
module testbench;

  localparam int IN_W   = 24;
  localparam int OUT_W  = 16;
  localparam int FRAC   = 16;
  localparam int DRAIN  = 30;
  localparam logic [IN_W-1:0]  IN_MAX   = {IN_W{1'b1}};
  localparam logic [OUT_W-1:0] OUT_FULL = {OUT_W{1'b1}};
  localparam logic [IN_W-1:0]  WHITE_RST = 24'd734003;

  typedef struct packed {
    logic [IN_W-1:0] r;
    logic [IN_W-1:0] g;
    logic [IN_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] r;
    logic [OUT_W-1:0] g;
    logic [OUT_W-1:0] b;
  } tone_t;

  logic clk, rst;
  logic start, busy, done;
  logic [IN_W-1:0] red_in, green_in, blue_in;
  logic [OUT_W-1:0] red_out, green_out, blue_out;
  logic cfg_valid, cfg_ready;
  ftm_pkg::cfg_idx_t cfg_index;
  logic [IN_W-1:0] cfg_data;

  pixel_t pending_pixels[$];
  tone_t  tones_due[$];
  logic [IN_W-1:0] white_pt[3];
  int mismatches = 0;
  int burst_left, gap_left;

  filmic_tonemap_rgb DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .done(done), .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact ratio f(x)/f(w) scaled to the output width and truncated, full scale
  // when x >= w. All products are carried at 192 bits, which holds the largest numerator.
  function automatic logic [OUT_W-1:0] tone_ratio(input logic [IN_W-1:0] x,
                                                  input logic [IN_W-1:0] w);
    logic [191:0] xx, ww, px, qx, pw, qw, quo;
    xx = 192'(x);
    ww = 192'(w);
    if (x >= w) return OUT_FULL;
    px = xx * (ftm_pkg::K_NUM_SQ * xx + (192'(ftm_pkg::K_LIN) << FRAC));
    qx = xx * (ftm_pkg::K_DEN_SQ * xx + (192'(ftm_pkg::K_LIN) << FRAC))
         + (192'(ftm_pkg::K_DEN_C) << (2 * FRAC));
    pw = ww * (ftm_pkg::K_NUM_SQ * ww + (192'(ftm_pkg::K_LIN) << FRAC));
    qw = ww * (ftm_pkg::K_DEN_SQ * ww + (192'(ftm_pkg::K_LIN) << FRAC))
         + (192'(ftm_pkg::K_DEN_C) << (2 * FRAC));
    quo = ((px * qw) << OUT_W) / (pw * qx);
    return (quo > OUT_FULL) ? OUT_FULL : quo[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Driver: an accepted word is turned into its expected tone, then the next
  // pending pixel is offered if the current burst still has room.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      red_in <= '0;
      green_in <= '0;
      blue_in <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        tones_due.push_back('{tone_ratio(red_in, white_pt[0]),
                              tone_ratio(green_in, white_pt[1]),
                              tone_ratio(blue_in, white_pt[2])});
        void'(pending_pixels.pop_front());
      end
      if (burst_left == 0 && gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        if (burst_left == 0) begin
          // Most bursts are long so back-to-back words get covered too.
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
        start <= 1'b1;
        red_in <= pending_pixels[0].r;
        green_in <= pending_pixels[0].g;
        blue_in <= pending_pixels[0].b;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: a result word lives for one cycle only, so it is taken at once.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (tones_due.size() == 0) begin
        report_mismatch("unexpected result word", 0, 0);
      end else begin
        tone_t want;
        want = tones_due.pop_front();
        if (red_out !== want.r) report_mismatch("red_out", red_out, want.r);
        if (green_out !== want.g) report_mismatch("green_out", green_out, want.g);
        if (blue_out !== want.b) report_mismatch("blue_out", blue_out, want.b);
      end
    end
  end

  // A register write is a handshake on its own channel; the bench copy of the
  // white points follows it, and an index past blue changes nothing.
  task automatic write_reg(input ftm_pkg::cfg_idx_t idx, input logic [IN_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ftm_pkg::REG_WHITE_RED) white_pt[0] = value;
    else if (idx == ftm_pkg::REG_WHITE_GREEN) white_pt[1] = value;
    else if (idx == ftm_pkg::REG_WHITE_BLUE) white_pt[2] = value;
  endtask

  task automatic wait_idle();
    wait (pending_pixels.size() == 0 && tones_due.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_whites(input logic [IN_W-1:0] wr, input logic [IN_W-1:0] wg,
                            input logic [IN_W-1:0] wb);
    write_reg(ftm_pkg::REG_WHITE_RED, wr);
    write_reg(ftm_pkg::REG_WHITE_GREEN, wg);
    write_reg(ftm_pkg::REG_WHITE_BLUE, wb);
  endtask

  // Random channel value: full range, below white, or hugging the white point.
  function automatic logic [IN_W-1:0] rand_chan(input logic [IN_W-1:0] w);
    int unsigned sel;
    logic [IN_W-1:0] v;
    sel = $urandom_range(0, 9);
    v = IN_W'($urandom);
    if (sel < 4) return v;
    if (sel < 8) return (w == 0) ? v : IN_W'($urandom_range(0, w - 1));
    return w + IN_W'($urandom_range(0, 4)) - IN_W'(2);
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      pending_pixels.push_back('{rand_chan(white_pt[0]), rand_chan(white_pt[1]),
                                 rand_chan(white_pt[2])});
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = ftm_pkg::REG_WHITE_RED;
    cfg_data = '0;
    white_pt[0] = WHITE_RST;
    white_pt[1] = WHITE_RST;
    white_pt[2] = WHITE_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (DRAIN) @(posedge clk);

    // Directed pixels at the reset white point: zero, tiny, one, just under,
    // at and above white, and the top of the input range.
    pending_pixels.push_back('{24'd0, 24'd1, IN_MAX});
    pending_pixels.push_back('{24'd65536, WHITE_RST - 1, WHITE_RST});
    pending_pixels.push_back('{WHITE_RST + 1, 24'd0, 24'd65536});
    pending_pixels.push_back('{IN_MAX, WHITE_RST, 24'd1});
    pending_pixels.push_back('{24'hAAAAAA, 24'h555555, 24'h0000FF});
    queue_random(200);
    wait_idle();

    // Smallest legal white point: anything nonzero saturates.
    set_whites(24'd1, 24'd1, 24'd1);
    pending_pixels.push_back('{24'd0, 24'd1, IN_MAX});
    queue_random(150);
    wait_idle();

    // Largest white point, so every input but the top of the range stays below it.
    set_whites(IN_MAX, IN_MAX, IN_MAX);
    pending_pixels.push_back('{IN_MAX - 1, IN_MAX, 24'd1});
    queue_random(200);
    wait_idle();

    // White point zero on red lies outside the range; every red input then saturates.
    set_whites(24'd0, 24'd65536, IN_MAX);
    pending_pixels.push_back('{24'd0, 24'd65535, 24'd0});
    queue_random(150);
    wait_idle();

    // A write past the blue register must leave the white points alone.
    set_whites(24'd65536, 24'd734003, 24'd3000000);
    write_reg(ftm_pkg::cfg_idx_t'(3), 24'd12345);
    queue_random(200);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      set_whites(IN_W'($urandom_range(1, 24'hFFFFFF)),
                 IN_W'($urandom_range(1, 24'h0FFFFF)),
                 IN_W'($urandom_range(1, 24'h7FFFFF)));
      queue_random(150);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
